### hdl/rau_pkg.sv
// Rational arithmetic unit package: op codes, word width, state, job and result types.
// No dependencies; used by the top level, divider, front, queue and back part.
package rau_pkg;
	localparam int unsigned WideWidth = 64;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_G1_DIV,
		ST_G1_WAIT,
		ST_QA,
		ST_QA_WAIT,
		ST_QB,
		ST_QB_WAIT,
		ST_MUL1,
		ST_MUL2,
		ST_G2_DIV,
		ST_G2_WAIT,
		ST_RN,
		ST_RN_WAIT,
		ST_RD,
		ST_RD_WAIT,
		ST_DONE
	} bstate_t;

	// Classified item handed from the front part to the back part.
	typedef struct packed {
		op_t               op;
		logic              err;
		logic signed [31:0] n1;
		logic signed [31:0] d1;
		logic signed [31:0] n2;
		logic signed [31:0] d2;
	} job_t;

	// Result transfer as it leaves the block.
	typedef struct packed {
		logic signed [31:0] result_numerator;
		logic signed [31:0] result_denominator;
		logic               error;
	} res_t;
endpackage

### hdl/rau_if.sv
// Valid/ready channel interface with source and sink modports.
// Depends on nothing; the payload type is a parameter.
interface rau_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/rational_arithmetic_unit.sv
// Rational arithmetic unit: two signed fractions combined by add, subtract,
// multiply or divide, result reduced by Euclid's gcd.
// Inputs arrive on channel "in", results leave on channel "out"; both are
// valid/ready; a transfer happens when valid and ready are high at a clock edge.
// The front part registers and classifies one item and passes it through a
// two-entry queue to the back part, which runs every division on one shared
// restoring divider. Add/subtract need the gcd loop of the denominators, two
// scaling divisions, the gcd loop of the raw result and two reducing divisions;
// multiply and divide skip the first three. The gcd loops run as long as the
// operands need; an error item skips every division.
// One item is in the back part at a time.
// Reset (arst_n low) empties the queue and the output register at once.
// A stalled receiver holds the result; the back part then finishes one more
// item and waits, and the queue and front register take up to three more items.
module rational_arithmetic_unit #(
	parameter int unsigned OPERAND_WIDTH = 16
) (
	input logic   clk,
	input logic   arst_n,
	rau_if.sink   in_ch,
	rau_if.source out_ch
);
	rau_pkg::job_t f_job, q_job;
	logic f_valid, f_ready, q_valid, q_ready;

	rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.mode(in_ch.data.mode),
		.first_numerator(OPERAND_WIDTH'(in_ch.data.first_numerator)),
		.first_denominator(OPERAND_WIDTH'(in_ch.data.first_denominator)),
		.second_numerator(OPERAND_WIDTH'(in_ch.data.second_numerator)),
		.second_denominator(OPERAND_WIDTH'(in_ch.data.second_denominator)),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.job_valid(f_valid), .job(f_job), .job_ready(f_ready)
	);

	rau_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
	);

	rau_pkg::res_t res;
	rau_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(q_valid), .job_ready(q_ready), .job(q_job),
		.res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
	);

	assign out_ch.data.result_numerator   = res.result_numerator;
	assign out_ch.data.result_denominator = res.result_denominator;
	assign out_ch.data.error              = res.error;
endmodule

### hdl/rau_div.sv
// Iterative signed 64-bit divider, truncating quotient and remainder as in C.
// Depends on rau_pkg for the word width; one quotient bit per cycle.
module rau_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [rau_pkg::WideWidth-1:0] dividend,
	input  logic signed [rau_pkg::WideWidth-1:0] divisor,
	output logic                                done,
	output logic signed [rau_pkg::WideWidth-1:0] quotient,
	output logic signed [rau_pkg::WideWidth-1:0] remainder
);
	localparam int unsigned W = rau_pkg::WideWidth;

	logic [W-1:0] quo_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] dvs_q;
	logic [$clog2(W+1)-1:0] cnt_q;
	logic busy_q;
	logic qneg_q;
	logic rneg_q;
	logic [W:0] trial;
	logic [W-1:0] shifted;

	// Restoring step on magnitudes.
	assign shifted = {rem_q[W-2:0], quo_q[W-1]};
	assign trial   = {1'b0, shifted} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(W+1))'(W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
			dvs_q  <= divisor[W-1] ? (~divisor + 1'b1) : divisor;
			rem_q  <= '0;
			qneg_q <= dividend[W-1] ^ divisor[W-1];
			rneg_q <= dividend[W-1];
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = qneg_q ? (~quo_q + 1'b1) : quo_q;
	assign remainder = rneg_q ? (~rem_q + 1'b1) : rem_q;
endmodule

### hdl/rau_front.sv
// Front part: takes an input transfer, sign-normalizes each fraction and flags errors.
// Depends on rau_pkg; writes one classified job into the queue.
module rau_front #(
	parameter int unsigned OPERAND_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [1:0]                      mode,
	input  logic signed [OPERAND_WIDTH-1:0] first_numerator,
	input  logic signed [OPERAND_WIDTH-1:0] first_denominator,
	input  logic signed [OPERAND_WIDTH-1:0] second_numerator,
	input  logic signed [OPERAND_WIDTH-1:0] second_denominator,
	input  logic                            in_valid,
	output logic                            in_ready,
	output logic                            job_valid,
	output rau_pkg::job_t                   job,
	input  logic                            job_ready
);
	logic signed [31:0] n1, d1, n2, d2, n1f, d1f, n2f, d2f;
	rau_pkg::job_t job_q;
	logic valid_q;

	assign n1 = 32'(first_numerator);
	assign d1 = 32'(first_denominator);
	assign n2 = 32'(second_numerator);
	assign d2 = 32'(second_denominator);

	// Both parts negative: negate both.
	always_comb begin
		n1f = n1;
		d1f = d1;
		n2f = n2;
		d2f = d2;
		if (n1 < 0 && d1 < 0) begin
			n1f = -n1;
			d1f = -d1;
		end
		if (n2 < 0 && d2 < 0) begin
			n2f = -n2;
			d2f = -d2;
		end
	end

	assign in_ready  = !valid_q || job_ready;
	assign job_valid = valid_q;
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job_q.op  <= rau_pkg::op_t'(mode);
			job_q.n1  <= n1f;
			job_q.d1  <= d1f;
			job_q.n2  <= n2f;
			job_q.d2  <= d2f;
			job_q.err <= (d1f == 0) || (d2f == 0) ||
				(rau_pkg::op_t'(mode) == rau_pkg::OP_DIV && n2f == 0);
		end
	end
endmodule

### hdl/rau_fifo.sv
// Two-entry queue between the front and back parts.
// Depends on rau_pkg for the job type.
module rau_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  rau_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output rau_pkg::job_t rd_data
);
	rau_pkg::job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

### hdl/rau_back.sv
// Back part: sequencer running gcd, scaling and reduction on one shared divider.
// Depends on rau_pkg and rau_div; emits one result transfer per job.
module rau_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  rau_pkg::job_t job,
	output logic          res_valid,
	input  logic          res_ready,
	output rau_pkg::res_t res
);
	localparam int unsigned W = rau_pkg::WideWidth;

	rau_pkg::bstate_t state_q, state_d;
	rau_pkg::job_t job_q;
	logic signed [W-1:0] ea_q, eb_q, ga_q, gb_q, rn_q, rd_q;
	logic signed [W-1:0] div_a, div_b, quo, rem;
	logic signed [W-1:0] den_raw;
	logic div_start, div_done;
	rau_pkg::res_t res_q;
	logic res_valid_q;
	logic can_load;

	// Signed 32 by 32 product, exact in 64 bits.
	function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p;
	endfunction

	rau_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b),
		.done(div_done), .quotient(quo), .remainder(rem)
	);

	assign can_load  = !res_valid_q || res_ready;
	assign job_ready = (state_q == rau_pkg::ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Raw denominator of multiply and divide.
	assign den_raw = (job_q.op == rau_pkg::OP_MUL) ? mul32(job_q.d1, job_q.d2)
		: mul32(job_q.d1, job_q.n2);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rau_pkg::ST_IDLE:
				if (job_valid) begin
					if (job.err)
						state_d = rau_pkg::ST_DONE;
					else if (job.op == rau_pkg::OP_ADD || job.op == rau_pkg::OP_SUB)
						state_d = rau_pkg::ST_G1_DIV;
					else
						state_d = rau_pkg::ST_MUL2;
				end
			rau_pkg::ST_G1_DIV: state_d = rau_pkg::ST_G1_WAIT;
			rau_pkg::ST_G1_WAIT:
				if (div_done) state_d = (rem == 0) ? rau_pkg::ST_QA : rau_pkg::ST_G1_DIV;
			rau_pkg::ST_QA: state_d = rau_pkg::ST_QA_WAIT;
			rau_pkg::ST_QA_WAIT: if (div_done) state_d = rau_pkg::ST_QB;
			rau_pkg::ST_QB: state_d = rau_pkg::ST_QB_WAIT;
			rau_pkg::ST_QB_WAIT: if (div_done) state_d = rau_pkg::ST_MUL1;
			rau_pkg::ST_MUL1: state_d = rau_pkg::ST_MUL2;
			// The raw denominator is never zero once errors are filtered out.
			rau_pkg::ST_MUL2: state_d = rau_pkg::ST_G2_DIV;
			rau_pkg::ST_G2_DIV: state_d = rau_pkg::ST_G2_WAIT;
			rau_pkg::ST_G2_WAIT:
				if (div_done) state_d = (rem == 0) ? rau_pkg::ST_RN : rau_pkg::ST_G2_DIV;
			rau_pkg::ST_RN: state_d = rau_pkg::ST_RN_WAIT;
			rau_pkg::ST_RN_WAIT: if (div_done) state_d = rau_pkg::ST_RD;
			rau_pkg::ST_RD: state_d = rau_pkg::ST_RD_WAIT;
			rau_pkg::ST_RD_WAIT: if (div_done) state_d = rau_pkg::ST_DONE;
			rau_pkg::ST_DONE: if (can_load) state_d = rau_pkg::ST_IDLE;
			default: state_d = rau_pkg::ST_IDLE;
		endcase
	end

	// Divider operand selection.
	always_comb begin
		div_start = 1'b0;
		div_a = ea_q;
		div_b = eb_q;
		unique case (state_q)
			rau_pkg::ST_G1_DIV, rau_pkg::ST_G2_DIV: div_start = 1'b1;
			rau_pkg::ST_QA: begin
				div_start = 1'b1;
				div_a = W'(job_q.d1);
				div_b = ga_q;
			end
			rau_pkg::ST_QB: begin
				div_start = 1'b1;
				div_a = W'(job_q.d2);
				div_b = ga_q;
			end
			rau_pkg::ST_RN: begin
				div_start = 1'b1;
				div_a = rn_q;
				div_b = gb_q;
			end
			rau_pkg::ST_RD: begin
				div_start = 1'b1;
				div_a = rd_q;
				div_b = gb_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rau_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rau_pkg::ST_DONE && can_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	// Datapath registers. Products are 32x32 at most; ST_MUL1 forms three of them together.
	always_ff @(posedge clk) begin
		unique case (state_q)
			rau_pkg::ST_IDLE:
				if (job_valid) begin
					job_q <= job;
					ea_q  <= W'(job.d1);
					eb_q  <= W'(job.d2);
					gb_q  <= 64'sd1;
					if (job.op == rau_pkg::OP_MUL) begin
						rn_q <= mul32(job.n1, job.n2);
					end else begin
						rn_q <= mul32(job.n1, job.d2);
					end
				end
			rau_pkg::ST_G1_WAIT:
				if (div_done) begin
					if (rem == 0) begin
						ga_q <= eb_q;
					end else begin
						ea_q <= eb_q;
						eb_q <= rem;
					end
				end
			rau_pkg::ST_QA_WAIT: if (div_done) ea_q <= quo;
			rau_pkg::ST_QB_WAIT: if (div_done) eb_q <= quo;
			rau_pkg::ST_MUL1: begin
				// ea = d1/g, eb = d2/g; the lcd is d1*(d2/g).
				if (job_q.op == rau_pkg::OP_ADD)
					rn_q <= mul32(job_q.n2, ea_q[31:0]) + mul32(job_q.n1, eb_q[31:0]);
				else
					rn_q <= mul32(job_q.n1, eb_q[31:0]) - mul32(job_q.n2, ea_q[31:0]);
				rd_q <= mul32(job_q.d1, eb_q[31:0]);
			end
			rau_pkg::ST_MUL2: begin
				if (job_q.op == rau_pkg::OP_MUL || job_q.op == rau_pkg::OP_DIV)
					rd_q <= den_raw;
				ea_q <= rn_q;
				eb_q <= (job_q.op == rau_pkg::OP_ADD || job_q.op == rau_pkg::OP_SUB)
					? rd_q : den_raw;
			end
			rau_pkg::ST_G2_WAIT:
				if (div_done) begin
					if (rem == 0) begin
						gb_q <= eb_q;
					end else begin
						ea_q <= eb_q;
						eb_q <= rem;
					end
				end
			rau_pkg::ST_RN_WAIT: if (div_done) rn_q <= quo;
			rau_pkg::ST_RD_WAIT: if (div_done) rd_q <= quo;
			default: ;
		endcase
		if (state_q == rau_pkg::ST_DONE && can_load) begin
			res_q.error              <= job_q.err;
			res_q.result_numerator   <= job_q.err ? 32'sd0 : rn_q[31:0];
			res_q.result_denominator <= job_q.err ? 32'sd0 : rd_q[31:0];
		end
	end
endmodule

### hdl/rau_checker.sv
// Port-level checker for the rational arithmetic unit, bound to the top level.
// Depends on the top level's channel signals only.
module rau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_num,
	input logic [31:0] out_den,
	input logic        out_err
);
	// A held result keeps its numerator and denominator while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_num) && $stable(out_den))
		else $error("result changed while stalled");

	// An error result carries zero parts.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_err |-> out_num == 0 && out_den == 0)
		else $error("error result not zero");

	// No result appears the cycle after reset release without an input.
	a_nores: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result without input");

	// A successful result never has a zero denominator.
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_err |-> out_den != 0)
		else $error("zero denominator without error");

	// The input ready is a defined level whenever an item is offered.
	a_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !$isunknown(in_ready))
		else $error("input ready unknown");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_num(out_ch.data.result_numerator),
	.out_den(out_ch.data.result_denominator),
	.out_err(out_ch.data.error)
);

### sim/rational_arithmetic_unit_tb.sv
// Testbench for the rational arithmetic unit: drives operand pairs and checks each
// reduced fraction against a built-in predictor. Depends on rau_pkg and rau_if.
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;
	// One input transfer: operation and the two fractions.
	typedef struct packed {
		rau_pkg::op_t       mode;
		logic signed [15:0] first_numerator;
		logic signed [15:0] first_denominator;
		logic signed [15:0] second_numerator;
		logic signed [15:0] second_denominator;
	} operands_t;

	localparam int unsigned WatchdogLimit = 40000;
	localparam int unsigned LongHold = 6000;

	logic clk;
	logic arst_n;

	rau_if #(.T(operands_t))     in_ch ();
	rau_if #(.T(rau_pkg::res_t)) out_ch ();

	rational_arithmetic_unit #(.OPERAND_WIDTH(16)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	operands_t     pending_ops[$];
	rau_pkg::res_t expected_fractions[$];
	int unsigned   mismatches = 0;
	int unsigned   results_seen = 0;
	int unsigned   idle_cycles = 0;
	bit            input_taken = 0;
	int unsigned   burst_left = 0;
	int unsigned   gap_left = 0;
	int unsigned   hold_left = 0;
	bit            hold_done = 0;

	// Clock.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Euclid's loop with truncating remainder; the answer may be negative.
	function automatic longint euclid_gcd(longint a, longint b);
		longint r;
		if (b == 0) begin
			return 1;
		end
		while (a % b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return b;
	endfunction

	// Expected reduced fraction for one operand set.
	function automatic rau_pkg::res_t reduce_fraction(operands_t op);
		longint n1, d1, n2, d2, rn, rd, g, gd;
		rau_pkg::res_t r;
		n1 = longint'(op.first_numerator);
		d1 = longint'(op.first_denominator);
		n2 = longint'(op.second_numerator);
		d2 = longint'(op.second_denominator);
		r = '0;
		if (n1 < 0 && d1 < 0) begin
			n1 = -n1;
			d1 = -d1;
		end
		if (n2 < 0 && d2 < 0) begin
			n2 = -n2;
			d2 = -d2;
		end
		if (d1 == 0 || d2 == 0 || (op.mode == rau_pkg::OP_DIV && n2 == 0)) begin
			r.error = 1'b1;
			return r;
		end
		case (op.mode)
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				gd = euclid_gcd(d1, d2);
				if (op.mode == rau_pkg::OP_ADD) begin
					rn = n2 * (d1 / gd) + n1 * (d2 / gd);
				end else begin
					rn = n1 * (d2 / gd) - n2 * (d1 / gd);
				end
				rd = (d1 * d2) / gd;
			end
			rau_pkg::OP_MUL: begin
				rn = n1 * n2;
				rd = d1 * d2;
			end
			default: begin
				rn = n1 * d2;
				rd = d1 * n2;
			end
		endcase
		g = euclid_gcd(rn, rd);
		r.result_numerator = 32'(rn / g);
		r.result_denominator = 32'(rd / g);
		return r;
	endfunction

	// Random operand: full width, small magnitude, or an extreme value.
	function automatic logic [15:0] pick_operand();
		case ($urandom_range(0, 9))
			0, 1, 2: return 16'($urandom);
			3: return 16'($urandom_range(0, 1) ? 32767 : -32767);
			4: return 16'($urandom_range(0, 1) ? -32768 : 0);
			default: return 16'(int'($urandom_range(0, 40)) - 20);
		endcase
	endfunction

	function automatic operands_t make_ops(rau_pkg::op_t m, int a, int b, int c, int d);
		operands_t op;
		op.mode = m;
		op.first_numerator = 16'(a);
		op.first_denominator = 16'(b);
		op.second_numerator = 16'(c);
		op.second_denominator = 16'(d);
		return op;
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && !input_taken) begin
				in_ch.valid <= 1'b1;
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_ch.valid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				in_ch.data <= pending_ops.pop_front();
				in_ch.valid <= 1'b1;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls on its own pattern, with one long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ch.ready <= 1'b0;
			end else if (!hold_done && results_seen == 200) begin
				hold_done <= 1'b1;
				hold_left <= LongHold;
				out_ch.ready <= 1'b0;
			end else if ((results_seen / 64) % 3 == 0) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Input transfer: record the expected fraction.
	always @(posedge clk) begin
		input_taken = 1'b0;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			expected_fractions.push_back(reduce_fraction(in_ch.data));
			input_taken = 1'b1;
		end
	end

	// Output transfer: compare with the oldest expected fraction.
	always @(posedge clk) begin
		rau_pkg::res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen = results_seen + 1;
			if (expected_fractions.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10) begin
					$display("Unexpected result %0d/%0d err %0b",
						out_ch.data.result_numerator, out_ch.data.result_denominator,
						out_ch.data.error);
				end
			end else begin
				want = expected_fractions.pop_front();
				if (out_ch.data.result_numerator !== want.result_numerator ||
						out_ch.data.result_denominator !== want.result_denominator ||
						out_ch.data.error !== want.error) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10) begin
						$display("Mismatch: expected %0d/%0d err %0b, got %0d/%0d err %0b",
							want.result_numerator, want.result_denominator, want.error,
							out_ch.data.result_numerator, out_ch.data.result_denominator,
							out_ch.data.error);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WatchdogLimit) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		operands_t op;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;

		// Directed items: extremes, every operation and the special cases.
		pending_ops.push_back(make_ops(rau_pkg::OP_ADD, 1, 2, 1, 3));
		pending_ops.push_back(make_ops(rau_pkg::OP_SUB, 1, 2, 1, 3));
		pending_ops.push_back(make_ops(rau_pkg::OP_MUL, 2, 3, 9, 4));
		pending_ops.push_back(make_ops(rau_pkg::OP_DIV, 2, 3, 4, 9));
		pending_ops.push_back(make_ops(rau_pkg::OP_ADD, -3, -4, -5, -6));
		pending_ops.push_back(make_ops(rau_pkg::OP_SUB, -3, 4, 5, -6));
		pending_ops.push_back(make_ops(rau_pkg::OP_ADD, 1, 0, 1, 2));
		pending_ops.push_back(make_ops(rau_pkg::OP_MUL, 1, 2, 1, 0));
		pending_ops.push_back(make_ops(rau_pkg::OP_DIV, 1, 2, 0, 5));
		pending_ops.push_back(make_ops(rau_pkg::OP_DIV, 1, 2, 0, -5));
		pending_ops.push_back(make_ops(rau_pkg::OP_ADD, 0, 5, 0, 7));
		pending_ops.push_back(make_ops(rau_pkg::OP_MUL, 0, -5, 3, 7));
		pending_ops.push_back(make_ops(rau_pkg::OP_SUB, 3, 7, 3, 7));
		pending_ops.push_back(make_ops(rau_pkg::OP_MUL, 32767, 32767, 32767, 32767));
		pending_ops.push_back(make_ops(rau_pkg::OP_ADD, 32767, -32767, -32767, 32767));
		pending_ops.push_back(make_ops(rau_pkg::OP_DIV, -32768, 32767, -32768, 32767));
		pending_ops.push_back(make_ops(rau_pkg::OP_MUL, -32768, -32768, -32768, -32768));
		pending_ops.push_back(make_ops(rau_pkg::OP_SUB, -32768, 1, 32767, -32768));
		pending_ops.push_back(make_ops(rau_pkg::OP_ADD, 32767, 32766, 32765, 32764));
		pending_ops.push_back(make_ops(rau_pkg::OP_DIV, 32767, -1, -32767, 1));

		// Random items.
		for (int i = 0; i < 1300; i++) begin
			op.mode = rau_pkg::op_t'($urandom_range(0, 3));
			op.first_numerator = pick_operand();
			op.first_denominator = pick_operand();
			op.second_numerator = pick_operand();
			op.second_denominator = pick_operand();
			pending_ops.push_back(op);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_ops.size() == 0);
		@(posedge clk);
		wait (!in_ch.valid);
		wait (expected_fractions.size() == 0);
		repeat (200) @(posedge clk);

		if (mismatches == 0 && expected_fractions.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
